// ===== hw/rtl/wavetable_oscillator_interp_core_macros.svh =====
// assertion macros used by the oscillator checker
// no dependencies; every macro takes clock and active-low reset explicitly
`ifndef WAVETABLE_OSCILLATOR_INTERP_CORE_MACROS_SVH
`define WAVETABLE_OSCILLATOR_INTERP_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define WTOSC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("oscillator port check failed");

// next-cycle implication, disabled during reset
`define WTOSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("oscillator port check failed");

`endif

// ===== hw/rtl/wtosc_pkg.sv =====
// shared constants and codes for the wavetable oscillator
// no dependencies
`default_nettype none

package wtosc_pkg;

	// table and sample geometry
	localparam int TABLE_BITS   = 10;
	localparam int SAMPLE_WIDTH = 16;
	localparam int TABLE_SIZE   = 1 << TABLE_BITS;
	localparam int FRAC_BITS    = 32 - TABLE_BITS;
	localparam int PROD_W       = FRAC_BITS + SAMPLE_WIDTH + 2;

	// stream field layout, input tdata: table_index, table_sample, freq
	localparam int IDX_IN_W     = 10;
	localparam int SMP_IN_W     = 16;
	localparam int FREQ_W       = 32;
	localparam int IDX_LSB      = 0;
	localparam int SMP_LSB      = IDX_LSB + IDX_IN_W;
	localparam int FREQ_LSB     = SMP_LSB + SMP_IN_W;
	localparam int IN_TDATA_W   = ((FREQ_LSB + FREQ_W + 7) / 8) * 8;
	localparam int IN_TUSER_W   = 2;
	localparam int OUT_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;

	// configuration port
	localparam int APB_ADDR_W   = 4;
	localparam int APB_DATA_W   = 32;

	// reset values of the registers
	localparam logic        INTERP_MODE_RST = 1'b1;
	localparam logic [31:0] RATE_SCALE_RST  = 32'd22906492;
	localparam logic [31:0] START_PHASE_RST = 32'd0;

	// commands carried in tuser
	typedef enum logic [IN_TUSER_W-1:0] {
		CMD_TICK    = 2'd0,
		CMD_LOAD    = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	// register index (paddr word address)
	typedef enum logic [1:0] {
		REG_INTERP_MODE = 2'd0,
		REG_RATE_SCALE  = 2'd1,
		REG_START_PHASE = 2'd2
	} reg_idx_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wtosc_ram.sv =====
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
`default_nettype none

module wtosc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/wavetable_oscillator_interp_core.sv =====
// a tick passes stage 1, the table read (two ram ports, entry and next entry)
// into stage 2, the interpolation multiply into stage 3, the output register onto m_axis
// throughput: one beat per cycle, any mix of commands, unless m_axis stalls a tick
// reset: asynchronous, active low; clears pipeline valids and phase, loads register
// reset values; table contents stay undefined until written
// wavetable oscillator top level; depends on wtosc_pkg and wtosc_ram
`default_nettype none

module wavetable_oscillator_interp_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input beats
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// [9:0] table_index, [25:10] table_sample, [57:26] freq, [63:58] zero
	input  wire logic [wtosc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// [1:0] cmd
	input  wire logic [wtosc_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
	// result beats
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// [15:0] sample
	output logic      [wtosc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// configuration
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [wtosc_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [wtosc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [wtosc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                     pready
);

	import wtosc_pkg::*;

	// configuration registers
	logic        interp_mode_q;
	logic [31:0] rate_scale_q;
	logic [31:0] start_phase_q;
	reg_idx_t    reg_sel;
	logic        cfg_wr;

	// stage 1: accepted beat
	logic                    valid_s1;
	logic [IN_TUSER_W-1:0]   cmd_s1;
	logic [TABLE_BITS-1:0]   tidx_s1;
	logic [SAMPLE_WIDTH-1:0] tsmp_s1;
	logic [31:0]             incr_s1;

	// stage 2: table read in flight
	logic                    valid_s2;
	logic [FRAC_BITS-1:0]    frac_s2;
	logic [SAMPLE_WIDTH-1:0] ent_a;
	logic [SAMPLE_WIDTH-1:0] ent_b;

	// stage 3: product registered
	logic                    valid_s3;
	logic [SAMPLE_WIDTH-1:0] a_s3;
	logic signed [PROD_W-1:0] prod_s3;

	// output register
	logic                    out_valid_q;
	logic [SAMPLE_WIDTH-1:0] out_sample_q;

	// phase accumulator
	logic [31:0] phase_q;

	// combinational
	logic                    in_beat;
	logic                    en_out, en3, en2, move1;
	logic                    tick_s1, load_s1;
	logic signed [63:0]      incr_prod;
	logic [TABLE_BITS-1:0]   rd_idx;
	logic [TABLE_BITS-1:0]   rd_nxt;
	logic signed [SAMPLE_WIDTH:0] diff_c;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [PROD_W-1:0] step_full;
	logic [SAMPLE_WIDTH:0]   sum_c;

	// apb decode, writes in the access phase
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interp_mode_q <= INTERP_MODE_RST;
			rate_scale_q  <= RATE_SCALE_RST;
			start_phase_q <= START_PHASE_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_INTERP_MODE: interp_mode_q <= pwdata[0];
				REG_RATE_SCALE:  rate_scale_q  <= pwdata;
				REG_START_PHASE: start_phase_q <= pwdata;
				default: ;
			endcase
		end
	end

	// register read-back
	always_comb begin
		unique case (reg_sel)
			REG_INTERP_MODE: prdata = {31'd0, interp_mode_q};
			REG_RATE_SCALE:  prdata = rate_scale_q;
			REG_START_PHASE: prdata = start_phase_q;
			default:         prdata = '0;
		endcase
	end

	// stage enables: a stage moves when the next has room; non-tick beats leave stage 1 freely
	assign tick_s1 = valid_s1 && (cmd_s1 == CMD_TICK);
	assign load_s1 = valid_s1 && (cmd_s1 == CMD_LOAD);
	assign en_out  = !out_valid_q || m_axis_tready;
	assign en3     = !valid_s3 || en_out;
	assign en2     = !valid_s2 || en3;
	assign move1   = valid_s1 && ((cmd_s1 != CMD_TICK) || en2);
	assign s_axis_tready = !valid_s1 || move1;
	assign in_beat = s_axis_tvalid && s_axis_tready;

	// phase increment: signed freq times unsigned rate scale, bits 47:16
	assign incr_prod = 64'($signed(s_axis_tdata[FREQ_LSB +: FREQ_W]))
		* 64'($signed({1'b0, rate_scale_q}));

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_beat) begin
			cmd_s1  <= s_axis_tuser;
			tidx_s1 <= TABLE_BITS'(s_axis_tdata[IDX_LSB +: IDX_IN_W]);
			tsmp_s1 <= SAMPLE_WIDTH'($signed(s_axis_tdata[SMP_LSB +: SMP_IN_W]));
			incr_s1 <= incr_prod[47:16];
		end
	end

	// as the stage 1 beat leaves, a tick advances the phase and a restart reloads it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (move1) begin
			unique case (cmd_s1)
				CMD_TICK:    phase_q <= phase_q + incr_s1;
				CMD_RESTART: phase_q <= start_phase_q;
				default:     ;
			endcase
		end
	end

	// table: two copies so that an entry and its neighbour read together
	assign rd_idx = phase_q[31:FRAC_BITS];
	assign rd_nxt = rd_idx + TABLE_BITS'(1);

	wtosc_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(TABLE_SIZE)
	) u_ram_a (
		.clk  (clk),
		.we   (load_s1),
		.waddr(tidx_s1),
		.wdata(tsmp_s1),
		.re   (en2),
		.raddr(rd_idx),
		.rdata(ent_a)
	);

	wtosc_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(TABLE_SIZE)
	) u_ram_b (
		.clk  (clk),
		.we   (load_s1),
		.waddr(tidx_s1),
		.wdata(tsmp_s1),
		.re   (en2),
		.raddr(rd_nxt),
		.rdata(ent_b)
	);

	// stage 2, only ticks travel on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= move1 && tick_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			frac_s2 <= phase_q[FRAC_BITS-1:0];
		end
	end

	// fraction times entry difference, zero when truncating
	assign diff_c = $signed({ent_b[SAMPLE_WIDTH-1], ent_b})
		- $signed({ent_a[SAMPLE_WIDTH-1], ent_a});
	assign prod_c = $signed({1'b0, frac_s2}) * diff_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			a_s3    <= ent_a;
			prod_s3 <= interp_mode_q ? prod_c : '0;
		end
	end

	// floor of the scaled step, then add; result lies between the two entries
	assign step_full = prod_s3 >>> FRAC_BITS;
	assign sum_c     = {a_s3[SAMPLE_WIDTH-1], a_s3} + step_full[SAMPLE_WIDTH:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			out_sample_q <= sum_c[SAMPLE_WIDTH-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_sample_q);

endmodule

`default_nettype wire

// ===== hw/rtl/wtosc_checker.sv =====
// port-level checks for the wavetable oscillator, bound to the top level
// depends on wavetable_oscillator_interp_core_macros.svh
`default_nettype none

`include "wavetable_oscillator_interp_core_macros.svh"

module wtosc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata,
	input wire logic        pready
);

	// a result beat waiting is held until taken
	`WTOSC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

	// a stalled result keeps its sample
	`WTOSC_ASSERT_NEXT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

	// with the output empty the pipeline never backs up to the input
	`WTOSC_ASSERT_NOW(a_in_free, clk, arst_n, !m_axis_tvalid, s_axis_tready)

	// the configuration port never inserts wait states
	`WTOSC_ASSERT_NOW(a_pready, clk, arst_n, 1'b1, pready)

endmodule

bind wavetable_oscillator_interp_core wtosc_checker u_wtosc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.pready       (pready)
);

`default_nettype wire

// ===== test/tb_wavetable_oscillator_interp_core.sv =====
// self-checking testbench for the wavetable oscillator top level
// depends on wtosc_pkg and the oscillator rtl; the sample predictor lives in a small class here
`timescale 1ns / 1ps

module tb_wavetable_oscillator_interp_core;
	import wtosc_pkg::*;

	// command code outside the defined set, the block must ignore it
	localparam logic [IN_TUSER_W-1:0] CMD_UNUSED = 2'd3;
	// settle time after the last expected sample before a register write or the end
	localparam int DRAIN_CYCLES = 8;

	// predicts output samples and holds those still due
	class sample_predictor;
		bit                              interp_on;
		logic [31:0]                     rate;
		logic [31:0]                     start;
		logic [31:0]                     phase;
		logic signed [SAMPLE_WIDTH-1:0]  wave [TABLE_SIZE];
		bit                              written [TABLE_SIZE];
		logic signed [SAMPLE_WIDTH-1:0]  samples_due [$];
		int                              errors;

		function new();
			interp_on = INTERP_MODE_RST;
			rate      = RATE_SCALE_RST;
			start     = START_PHASE_RST;
			phase     = '0;
			errors    = 0;
			foreach (wave[i]) begin
				wave[i]    = '0;
				written[i] = 1'b0;
			end
		endfunction

		function void set_reg(reg_idx_t r, logic [31:0] v);
			case (r)
				REG_INTERP_MODE: interp_on = v[0];
				REG_RATE_SCALE:  rate = v;
				REG_START_PHASE: start = v;
				default: ;
			endcase
		endfunction

		// table read at the current phase, truncated or interpolated
		function logic signed [SAMPLE_WIDTH-1:0] lookup();
			logic [TABLE_BITS-1:0] idx;
			logic [TABLE_BITS-1:0] nxt;
			logic [FRAC_BITS-1:0]  frac;
			longint                a;
			longint                b;
			longint                prod;
			idx  = phase[31:FRAC_BITS];
			nxt  = idx + TABLE_BITS'(1);
			frac = phase[FRAC_BITS-1:0];
			if (!interp_on)
				return wave[idx];
			a    = wave[idx];
			b    = wave[nxt];
			prod = longint'(frac) * (b - a);
			return SAMPLE_WIDTH'(a + (prod >>> FRAC_BITS));
		endfunction

		// accepted input beat: update table and phase, queue a sample on tick
		function void note_beat(logic [IN_TUSER_W-1:0] cmd, logic [IN_TDATA_W-1:0] data);
			logic [TABLE_BITS-1:0] idx;
			logic signed [31:0]    freq;
			longint                prod;
			idx  = data[IDX_LSB +: TABLE_BITS];
			freq = data[FREQ_LSB +: FREQ_W];
			case (cmd)
				CMD_LOAD: begin
					wave[idx]    = data[SMP_LSB +: SAMPLE_WIDTH];
					written[idx] = 1'b1;
				end
				CMD_RESTART: phase = start;
				CMD_TICK: begin
					samples_due.push_back(lookup());
					prod  = longint'(freq) * longint'({32'd0, rate});
					phase = phase + prod[47:16];
				end
				default: ;
			endcase
		endfunction

		// accepted output beat against the oldest sample due
		function void check_sample(logic [SAMPLE_WIDTH-1:0] got);
			logic [SAMPLE_WIDTH-1:0] want;
			if (samples_due.size() == 0) begin
				$display("%0t: unexpected sample beat, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = samples_due.pop_front();
			if (got !== want) begin
				$display("%0t: sample mismatch, expected %h, actual %h", $time, want, got);
				errors++;
			end
		endfunction

		function int pending();
			return samples_due.size();
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	// [9:0] table_index, [25:10] table_sample, [57:26] freq, [63:58] zero
	logic [IN_TDATA_W-1:0]   s_axis_tdata;
	// [1:0] cmd
	logic [IN_TUSER_W-1:0]   s_axis_tuser;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	// [15:0] sample
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [APB_ADDR_W-1:0]   paddr;
	logic [APB_DATA_W-1:0]   pwdata;
	logic [APB_DATA_W-1:0]   prdata;
	logic                    pready;

	sample_predictor sb;
	int send_idle_pct;
	int recv_idle_pct;

	wavetable_oscillator_interp_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// output side: check each accepted beat, then decide next cycle's stall
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_sample(m_axis_tdata[SAMPLE_WIDTH-1:0]);
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// overall time limit
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [IN_TDATA_W-1:0] pack_beat(logic [IDX_IN_W-1:0] idx,
			logic [SMP_IN_W-1:0] smp, logic [FREQ_W-1:0] freq);
		logic [IN_TDATA_W-1:0] d;
		d = '0;
		d[IDX_LSB +: IDX_IN_W] = idx;
		d[SMP_LSB +: SMP_IN_W] = smp;
		d[FREQ_LSB +: FREQ_W]  = freq;
		return d;
	endfunction

	// one input beat with random sender gaps; the predictor sees it at acceptance
	task automatic send_beat(logic [IN_TUSER_W-1:0] cmd, logic [IN_TDATA_W-1:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= cmd;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_beat(cmd, data);
	endtask

	task automatic send_load(logic [IDX_IN_W-1:0] idx, logic [SMP_IN_W-1:0] smp);
		send_beat(CMD_LOAD, pack_beat(idx, smp, $urandom()));
	endtask

	// tick, first loading any entry it would read that was never written
	task automatic send_tick(logic [FREQ_W-1:0] freq);
		logic [TABLE_BITS-1:0] idx;
		logic [TABLE_BITS-1:0] nxt;
		idx = sb.phase[31:FRAC_BITS];
		nxt = idx + TABLE_BITS'(1);
		if (!sb.written[idx])
			send_load(idx, SMP_IN_W'($urandom()));
		if (!sb.written[nxt])
			send_load(nxt, SMP_IN_W'($urandom()));
		send_beat(CMD_TICK, pack_beat(IDX_IN_W'($urandom()), SMP_IN_W'($urandom()), freq));
	endtask

	// stop the stream and wait for every due sample plus the pipeline tail
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write then read-back over the configuration port
	task automatic write_reg(reg_idx_t r, logic [31:0] v);
		logic [31:0] want;
		logic [31:0] got;
		want = (r == REG_INTERP_MODE) ? {31'd0, v[0]} : v;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_reg(r, v);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== want) begin
			$display("%0t: register %0d read-back, expected %h, actual %h", $time, r, want, got);
			sb.errors++;
		end
	endtask

	// frequency mostly small so the phase walks through neighbouring entries
	function automatic logic [FREQ_W-1:0] pick_freq();
		logic [31:0] f;
		f = $urandom();
		case ($urandom_range(9))
			0, 1, 2, 3: f = {{16{f[31]}}, f[15:0]};
			4, 5, 6:    f = {{8{f[31]}}, f[23:0]};
			8: begin
				case ($urandom_range(3))
					0: f = 32'h7FFF_FFFF;
					1: f = 32'h8000_0000;
					2: f = 32'h0000_0000;
					default: f = 32'hFFFF_FFFF;
				endcase
			end
			default: ;
		endcase
		return f;
	endfunction

	// mostly ticks with loads and restarts mixed in, a few ignored commands
	task automatic run_random(int count);
		int n;
		int r;
		for (n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 70)
				send_tick(pick_freq());
			else if (r < 85)
				send_load(IDX_IN_W'($urandom()), SMP_IN_W'($urandom()));
			else if (r < 93)
				send_beat(CMD_RESTART, pack_beat(IDX_IN_W'($urandom()),
					SMP_IN_W'($urandom()), $urandom()));
			else
				send_beat(CMD_UNUSED, pack_beat(IDX_IN_W'($urandom()),
					SMP_IN_W'($urandom()), $urandom()));
		end
	endtask

	// main sequence
	initial begin
		sb = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		send_idle_pct = 15;
		recv_idle_pct = 72;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme entries, extreme frequencies, wrap from last entry to first
		send_load(10'd0, 16'h7FFF);
		send_load(10'd1, 16'h8000);
		send_load(10'd1023, 16'hFFFF);
		send_load(10'd2, 16'h0000);
		send_load(10'd3, 16'h5555);
		send_load(10'd4, 16'hAAAA);
		send_tick(32'd0);
		send_tick(32'h7FFF_FFFF);
		send_tick(32'h8000_0000);
		send_beat(CMD_UNUSED, pack_beat(10'h3FF, 16'hFFFF, 32'hFFFF_FFFF));
		send_beat(CMD_RESTART, '0);
		send_tick(32'hFFFF_FFFF);
		send_tick(32'd1);
		send_tick(32'd0);
		send_beat(CMD_RESTART, pack_beat(10'h3FF, 16'hFFFF, 32'hFFFF_FFFF));
		send_tick(32'd6000);
		send_tick(32'd0);
		drain();
		write_reg(REG_START_PHASE, 32'hFFFF_FFFF);
		send_beat(CMD_RESTART, '0);
		send_tick(32'd0);
		drain();
		write_reg(REG_INTERP_MODE, 32'd0);
		send_tick(32'd0);
		send_tick(32'd6000);
		drain();

		// sender idles lightly, receiver stalls hard
		write_reg(REG_INTERP_MODE, 32'd1);
		write_reg(REG_RATE_SCALE, RATE_SCALE_RST);
		write_reg(REG_START_PHASE, $urandom());
		run_random(260);
		drain();

		// sender idles hard, receiver stalls lightly, truncating at the extremes
		send_idle_pct = 72;
		recv_idle_pct = 15;
		write_reg(REG_INTERP_MODE, 32'd0);
		write_reg(REG_RATE_SCALE, 32'hFFFF_FFFF);
		write_reg(REG_START_PHASE, 32'hFFFF_FFFF);
		run_random(260);
		drain();

		// no idling: frozen phase, then random settings
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_INTERP_MODE, 32'd1);
		write_reg(REG_RATE_SCALE, 32'd0);
		write_reg(REG_START_PHASE, 32'h8000_0000);
		run_random(40);
		drain();
		write_reg(REG_RATE_SCALE, $urandom());
		write_reg(REG_START_PHASE, $urandom());
		run_random(190);
		drain();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/wtosc_pkg.sv
hw/rtl/wtosc_ram.sv
hw/rtl/wavetable_oscillator_interp_core.sv
hw/rtl/wtosc_checker.sv
test/tb_wavetable_oscillator_interp_core.sv
